// ===== rtl/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

    localparam int unsigned FULL_SCALE    = 8160;
    localparam int unsigned HALF_SCALE    = 4080;
    localparam int unsigned HUE_CYCLE     = 192;
    localparam int unsigned SEXTANT_STEPS = 32;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SCALE_W = 13;   // 0..8160
    localparam int unsigned NUM_W   = 21;   // up to 255*8160 + 4080
    localparam int unsigned QUOT_W  = 16;   // NUM_W - 5, after dividing by 32

    typedef enum logic [2:0] {
        SEXTANT_RY = 3'd0,
        SEXTANT_YG = 3'd1,
        SEXTANT_GC = 3'd2,
        SEXTANT_CB = 3'd3,
        SEXTANT_BM = 3'd4,
        SEXTANT_MR = 3'd5
    } sextant_t;

    typedef struct packed {
        sextant_t                   sextant;
        logic [BYTE_W-1:0]          value;
        logic [SCALE_W-1:0]         scale_lo;
        logic [SCALE_W-1:0]         scale_fall;
        logic [SCALE_W-1:0]         scale_rise;
    } scale_beat_t;

    typedef struct packed {
        sextant_t                   sextant;
        logic [BYTE_W-1:0]          value;
        logic [NUM_W-1:0]           num_lo;
        logic [NUM_W-1:0]           num_fall;
        logic [NUM_W-1:0]           num_rise;
    } product_beat_t;

    typedef struct packed {
        sextant_t                   sextant;
        logic [BYTE_W-1:0]          value;
        logic [QUOT_W-1:0]          m_lo;
        logic [QUOT_W-1:0]          m_fall;
        logic [QUOT_W-1:0]          m_rise;
        logic [BYTE_W-1:0]          q_lo;
        logic [BYTE_W-1:0]          q_fall;
        logic [BYTE_W-1:0]          q_rise;
    } estimate_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0]          blue;
        logic [BYTE_W-1:0]          green;
        logic [BYTE_W-1:0]          red;
    } rgb_beat_t;

endpackage

// ===== rtl/hsv2rgb_scale.sv =====
module hsv2rgb_scale (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                hue,
    input  logic [7:0]                saturation,
    input  logic [7:0]                brightness,
    output logic                      out_valid,
    input  logic                      out_ready,
    output hsv2rgb_pkg::scale_beat_t  out_beat
);

    logic                     valid_reg;
    hsv2rgb_pkg::scale_beat_t beat_reg;
    hsv2rgb_pkg::scale_beat_t beat_next;

    logic [7:0]  hue_wrapped;
    logic [4:0]  frac;
    logic [5:0]  frac_rise;
    logic [12:0] s_lo;
    logic [12:0] s_fall;
    logic [12:0] s_rise;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        hue_wrapped = (hue >= 8'(hsv2rgb_pkg::HUE_CYCLE))
                    ? hue - 8'(hsv2rgb_pkg::HUE_CYCLE) : hue;
        frac      = hue_wrapped[4:0];
        frac_rise = 6'(hsv2rgb_pkg::SEXTANT_STEPS) - {1'b0, frac};
        s_lo      = {saturation, 5'd0};
        s_fall    = 13'(saturation * frac);
        s_rise    = 13'(saturation * frac_rise);

        beat_next.sextant    = hsv2rgb_pkg::sextant_t'(hue_wrapped[7:5]);
        beat_next.value      = brightness;
        beat_next.scale_lo   = 13'(hsv2rgb_pkg::FULL_SCALE) - s_lo;
        beat_next.scale_fall = 13'(hsv2rgb_pkg::FULL_SCALE) - s_fall;
        beat_next.scale_rise = 13'(hsv2rgb_pkg::FULL_SCALE) - s_rise;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ===== rtl/hsv2rgb_product.sv =====
module hsv2rgb_product (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  hsv2rgb_pkg::scale_beat_t    in_beat,
    output logic                        out_valid,
    input  logic                        out_ready,
    output hsv2rgb_pkg::product_beat_t  out_beat
);

    logic                       valid_reg;
    hsv2rgb_pkg::product_beat_t beat_reg;
    hsv2rgb_pkg::product_beat_t beat_next;

    assign in_ready = !valid_reg || out_ready;

    // v * scale + half scale, ready for the rounding divide
    always_comb
    begin
        beat_next.sextant  = in_beat.sextant;
        beat_next.value    = in_beat.value;
        beat_next.num_lo   = 21'(in_beat.value * in_beat.scale_lo)
                           + 21'(hsv2rgb_pkg::HALF_SCALE);
        beat_next.num_fall = 21'(in_beat.value * in_beat.scale_fall)
                           + 21'(hsv2rgb_pkg::HALF_SCALE);
        beat_next.num_rise = 21'(in_beat.value * in_beat.scale_rise)
                           + 21'(hsv2rgb_pkg::HALF_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ===== rtl/hsv2rgb_divide.sv =====
module hsv2rgb_divide (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  hsv2rgb_pkg::product_beat_t  in_beat,
    output logic                        out_valid,
    input  logic                        out_ready,
    output hsv2rgb_pkg::rgb_beat_t      out_beat
);

    // n / 8160 == (n >> 5) / 255; the quotient by 255 is estimated as
    // (m * 257) >> 16, which is exact or one low, then corrected.

    logic                        est_valid_reg;
    logic                        est_ready;
    hsv2rgb_pkg::estimate_beat_t est_reg;
    hsv2rgb_pkg::estimate_beat_t est_next;

    logic                        rgb_valid_reg;
    hsv2rgb_pkg::rgb_beat_t      rgb_reg;
    hsv2rgb_pkg::rgb_beat_t      rgb_next;

    logic [7:0] lvl_lo;
    logic [7:0] lvl_fall;
    logic [7:0] lvl_rise;

    function automatic logic [7:0] estimate(input logic [15:0] m);
        logic [24:0] prod;
        prod = {9'd0, m} + {1'b0, m, 8'd0};
        return prod[23:16];
    endfunction

    function automatic logic [7:0] correct(input logic [15:0] m, input logic [7:0] q);
        logic [16:0] rem;
        rem = {1'b0, m} - ({1'b0, q, 8'd0} - {9'd0, q});
        return (rem >= 17'd255) ? q + 8'd1 : q;
    endfunction

    assign in_ready  = !est_valid_reg || est_ready;
    assign est_ready = !rgb_valid_reg || out_ready;

    always_comb
    begin
        est_next.sextant = in_beat.sextant;
        est_next.value   = in_beat.value;
        est_next.m_lo    = in_beat.num_lo[20:5];
        est_next.m_fall  = in_beat.num_fall[20:5];
        est_next.m_rise  = in_beat.num_rise[20:5];
        est_next.q_lo    = estimate(in_beat.num_lo[20:5]);
        est_next.q_fall  = estimate(in_beat.num_fall[20:5]);
        est_next.q_rise  = estimate(in_beat.num_rise[20:5]);
    end

    always_comb
    begin
        lvl_lo   = correct(est_reg.m_lo, est_reg.q_lo);
        lvl_fall = correct(est_reg.m_fall, est_reg.q_fall);
        lvl_rise = correct(est_reg.m_rise, est_reg.q_rise);

        unique case (est_reg.sextant)
            hsv2rgb_pkg::SEXTANT_RY:
            begin
                rgb_next.red   = est_reg.value;
                rgb_next.green = lvl_rise;
                rgb_next.blue  = lvl_lo;
            end
            hsv2rgb_pkg::SEXTANT_YG:
            begin
                rgb_next.red   = lvl_fall;
                rgb_next.green = est_reg.value;
                rgb_next.blue  = lvl_lo;
            end
            hsv2rgb_pkg::SEXTANT_GC:
            begin
                rgb_next.red   = lvl_lo;
                rgb_next.green = est_reg.value;
                rgb_next.blue  = lvl_rise;
            end
            hsv2rgb_pkg::SEXTANT_CB:
            begin
                rgb_next.red   = lvl_lo;
                rgb_next.green = lvl_fall;
                rgb_next.blue  = est_reg.value;
            end
            hsv2rgb_pkg::SEXTANT_BM:
            begin
                rgb_next.red   = lvl_rise;
                rgb_next.green = lvl_lo;
                rgb_next.blue  = est_reg.value;
            end
            default:
            begin
                rgb_next.red   = est_reg.value;
                rgb_next.green = lvl_lo;
                rgb_next.blue  = lvl_fall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_valid_reg <= 1'b0;
            rgb_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                est_valid_reg <= in_valid;
            end
            if (est_ready)
            begin
                rgb_valid_reg <= est_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            est_reg <= est_next;
        end
        if (est_ready && est_valid_reg)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = rgb_valid_reg;
    assign out_beat  = rgb_reg;

endmodule

// ===== rtl/hsv_to_rgb_integer_top.sv =====
// HSV to RGB conversion, four register stages: sextant and scales, products,
// quotient estimate, correction with channel routing.
// Throughput: one beat per cycle; stages hold under backpressure, bubbles collapse.
// Reset (rst_n, async, active low) clears all stage valid bits; data is not reset.
module hsv_to_rgb_integer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // hue[7:0], saturation[15:8], brightness[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    logic                       scale_valid;
    logic                       scale_ready;
    hsv2rgb_pkg::scale_beat_t   scale_beat;
    logic                       prod_valid;
    logic                       prod_ready;
    hsv2rgb_pkg::product_beat_t prod_beat;
    hsv2rgb_pkg::rgb_beat_t     rgb_beat;

    hsv2rgb_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .hue        (s_axis_tdata[7:0]),
        .saturation (s_axis_tdata[15:8]),
        .brightness (s_axis_tdata[23:16]),
        .out_valid  (scale_valid),
        .out_ready  (scale_ready),
        .out_beat   (scale_beat)
    );

    hsv2rgb_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .in_ready  (scale_ready),
        .in_beat   (scale_beat),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_beat  (prod_beat)
    );

    hsv2rgb_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_beat   (prod_beat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_beat  (rgb_beat)
    );

    assign m_axis_tdata = {rgb_beat.blue, rgb_beat.green, rgb_beat.red};

endmodule

// ===== tb/sv/tb_hsv_to_rgb_integer_top.sv =====
module tb_hsv_to_rgb_integer_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_BEATS = 530;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 12;   // pipeline is 4 deep, plus slack

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        logic       known;   // expected color typed in below
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } hsv_case_t;

    localparam int DIRECTED_ROWS = 23;

    hsv_case_t directed_rows [DIRECTED_ROWS] = '{
        // grey and black
        '{8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{8'd0,   8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
        '{8'd100, 8'd0,   8'd77,  1'b1, 8'd77,  8'd77,  8'd77},
        '{8'd255, 8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
        // full saturation at each sextant start
        '{8'd0,   8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
        '{8'd32,  8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd0},
        '{8'd64,  8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0},
        '{8'd96,  8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd255},
        '{8'd128, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255},
        '{8'd160, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd255},
        '{8'd192, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
        '{8'd0,   8'd255, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        // hue wrap, sextant ends, mixed levels
        '{8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd31,  8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd63,  8'd128, 8'd200, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd95,  8'd1,   8'd1,   1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd127, 8'd254, 8'd254, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd159, 8'd200, 8'd100, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd191, 8'd255, 8'd128, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd224, 8'd170, 8'd85,  1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd250, 8'd85,  8'd170, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd1,   8'd128, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd33,  8'd64,  8'd32,  1'b0, 8'd0, 8'd0, 8'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // hue[7:0], saturation[15:8], brightness[23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // red[7:0], green[15:8], blue[23:16]

    hsv2rgb_pkg::rgb_beat_t pending_rgb [$];
    int                     mismatch_count = 0;
    int                     cycle_count = 0;
    int                     burst_left = 0;

    hsv_to_rgb_integer_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // rounded v * (8160 - s*k) / 8160
    function automatic logic [7:0] scaled_level(input logic [7:0] val, input logic [7:0] sat,
                                                input int unsigned k);
        int unsigned num;
        num = val * (hsv2rgb_pkg::FULL_SCALE - sat * k) + hsv2rgb_pkg::HALF_SCALE;
        return 8'(num / hsv2rgb_pkg::FULL_SCALE);
    endfunction

    function automatic hsv2rgb_pkg::rgb_beat_t hsv_to_rgb(input logic [7:0] hue,
                                                          input logic [7:0] sat,
                                                          input logic [7:0] val);
        int unsigned            h;
        int unsigned            t;
        logic [7:0]             lo;
        logic [7:0]             fall;
        logic [7:0]             rise;
        hsv2rgb_pkg::sextant_t  sx;
        hsv2rgb_pkg::rgb_beat_t px;
        h    = hue % hsv2rgb_pkg::HUE_CYCLE;
        t    = h % hsv2rgb_pkg::SEXTANT_STEPS;
        sx   = hsv2rgb_pkg::sextant_t'(h / hsv2rgb_pkg::SEXTANT_STEPS);
        lo   = scaled_level(val, sat, hsv2rgb_pkg::SEXTANT_STEPS);
        fall = scaled_level(val, sat, t);
        rise = scaled_level(val, sat, hsv2rgb_pkg::SEXTANT_STEPS - t);
        unique case (sx)
            hsv2rgb_pkg::SEXTANT_RY: px = '{blue: lo,   green: rise, red: val};
            hsv2rgb_pkg::SEXTANT_YG: px = '{blue: lo,   green: val,  red: fall};
            hsv2rgb_pkg::SEXTANT_GC: px = '{blue: rise, green: val,  red: lo};
            hsv2rgb_pkg::SEXTANT_CB: px = '{blue: val,  green: fall, red: lo};
            hsv2rgb_pkg::SEXTANT_BM: px = '{blue: val,  green: lo,   red: rise};
            default:                 px = '{blue: fall, green: lo,   red: val};  // magenta-red
        endcase
        return px;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // holds valid until the beat is taken, then queues its color
    task automatic drive_beat(input logic [7:0] hue, input logic [7:0] sat,
                              input logic [7:0] val, input hsv2rgb_pkg::rgb_beat_t want);
        s_axis_tdata  <= {val, sat, hue};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        pending_rgb.push_back(want);
    endtask

    // burst bookkeeping: a gap only opens when a burst runs out
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_rgb.size() != 0);
    endtask

    // receiver stall pattern, chosen by cycle_count[8:6]
    always @(posedge clk)
    begin
        case (cycle_count[8:6])
            3'd0, 3'd1: m_axis_tready <= 1'b1;
            3'd2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            3'd3:       m_axis_tready <= (cycle_count[2:0] != 3'd0);
            default:    m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // output beat checker
    always @(posedge clk)
    begin
        hsv2rgb_pkg::rgb_beat_t got;
        hsv2rgb_pkg::rgb_beat_t want;
        got = m_axis_tdata;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_rgb.size() == 0)
            begin
                report_mismatch("unexpected beat", int'(got), 0);
            end
            else
            begin
                want = pending_rgb.pop_front();
                if (got.red !== want.red)
                    report_mismatch("red", int'(got.red), int'(want.red));
                if (got.green !== want.green)
                    report_mismatch("green", int'(got.green), int'(want.green));
                if (got.blue !== want.blue)
                    report_mismatch("blue", int'(got.blue), int'(want.blue));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL hsv_to_rgb_integer_top");
            $finish;
        end
    end

    initial
    begin
        logic [7:0]             hue;
        logic [7:0]             sat;
        logic [7:0]             val;
        hsv2rgb_pkg::rgb_beat_t want;
        int                     pick;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].known)
            begin
                want.red   = directed_rows[i].red;
                want.green = directed_rows[i].green;
                want.blue  = directed_rows[i].blue;
            end
            else
            begin
                want = hsv_to_rgb(directed_rows[i].hue, directed_rows[i].sat,
                                  directed_rows[i].val);
            end
            drive_beat(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].val,
                       want);
            pace_sender();
        end
        wait_for_drain();

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            hue  = 8'($urandom_range(0, 255));
            sat  = 8'($urandom_range(0, 255));
            val  = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                sat = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
            else if (pick == 1)
                val = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
            else if (pick == 2)   // sextant start or end
                hue = 8'(32 * $urandom_range(0, 7) + 31 * $urandom_range(0, 1));
            drive_beat(hue, sat, val, hsv_to_rgb(hue, sat, val));
            if (i == RANDOM_BEATS / 2)
                wait_for_drain();
            else
                pace_sender();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS hsv_to_rgb_integer_top");
        else
            $display("FAIL hsv_to_rgb_integer_top");
        $finish;
    end

endmodule
